@@ hw/rtl/assert_macros.svh @@
// shared assertion macros for the decoder checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define HMBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define HMBD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ hw/rtl/hmbd_pkg.sv @@
package hmbd_pkg;

  // result target codes
  typedef enum logic [2:0] {
    TgtInternal = 3'd0,
    TgtBoot     = 3'd1,
    TgtCart     = 3'd2,
    TgtVram     = 3'd3,
    TgtTimer    = 3'd4,
    TgtVideo    = 3'd5,
    TgtIgnored  = 3'd6
  } target_e;

  // unified backing store: work ram, then sprite ram, then high ram
  localparam int WramDepth = 8192;
  localparam int OamSlots  = 256;
  localparam int HramSlots = 128;
  localparam int OamBase   = WramDepth;
  localparam int HramBase  = WramDepth + OamSlots;
  localparam int MemDepth  = WramDepth + OamSlots + HramSlots;
  localparam int MemAw     = $clog2(MemDepth);

  // configuration port
  localparam int PaddrW = 3;
  localparam logic CfgIdxBootRom = 1'b0;

  // memory map boundaries
  localparam logic [15:0] AddrBootEnd  = 16'h0100;
  localparam logic [15:0] AddrVramEnd  = 16'h9FFF;
  localparam logic [15:0] AddrXramEnd  = 16'hBFFF;
  localparam logic [15:0] AddrEchoEnd  = 16'hFDFF;
  localparam logic [15:0] AddrOamEnd   = 16'hFE9F;
  localparam logic [15:0] AddrHoleEnd  = 16'hFEFF;
  localparam logic [15:0] AddrTimerLo  = 16'hFF04;
  localparam logic [15:0] AddrTimerHi  = 16'hFF07;
  localparam logic [15:0] AddrVideoLo  = 16'hFF40;
  localparam logic [15:0] AddrVideoHi  = 16'hFF4B;
  localparam logic [15:0] AddrJoypad   = 16'hFF00;
  localparam logic [15:0] AddrSerData  = 16'hFF01;
  localparam logic [15:0] AddrSerCtrl  = 16'hFF02;
  localparam logic [15:0] AddrIrqFlags = 16'hFF0F;
  localparam logic [15:0] AddrBootOff  = 16'hFF50;
  localparam logic [15:0] AddrHramLo   = 16'hFF80;
  localparam logic [15:0] AddrIrqMask  = 16'hFFFF;

  // store write request
  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] idx;
    logic [7:0]       data;
  } mem_wr_t;

  // store read request
  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] idx;
  } mem_rd_t;

  // store slot of a bus address; only meaningful inside a ram region
  function automatic logic [MemAw-1:0] mem_index(input logic [15:0] addr);
    logic [MemAw-1:0] idx;
    if (addr >= AddrHramLo) begin
      idx = MemAw'(HramBase) + MemAw'(addr[6:0]);
    end else if (addr > AddrEchoEnd) begin
      idx = MemAw'(OamBase) + MemAw'(addr[7:0]);
    end else begin
      idx = MemAw'(addr[12:0]);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/hmbd_if.sv @@
// request channel: one cpu bus access
interface hmbd_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        dma_busy;
  logic [3:0]  action_buttons;
  logic [3:0]  direction_buttons;
  logic [4:0]  irq_set;

  modport source (
    output valid, op, address, write_data, dma_busy, action_buttons,
           direction_buttons, irq_set,
    input  ready
  );
  modport sink (
    input  valid, op, address, write_data, dma_busy, action_buttons,
           direction_buttons, irq_set,
    output ready
  );
endinterface

// response channel: decode result of one access
interface hmbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] target;
  logic       serial_valid;
  logic [7:0] serial_byte;
  logic [4:0] interrupt_flags;
  logic [4:0] interrupt_enable;

  modport source (
    output valid, read_data, target, serial_valid, serial_byte, interrupt_flags,
           interrupt_enable,
    input  ready
  );
  modport sink (
    input  valid, read_data, target, serial_valid, serial_byte, interrupt_flags,
           interrupt_enable,
    output ready
  );
endinterface

@@ hw/rtl/handheld_memory_bus_decoder_core.sv @@
// Memory bus decoder for an 8-bit handheld console.
// req_i takes one cpu bus access per request (op, address, write data,
// dma flag, live button lines, external interrupt requests); rsp_o returns
// exactly one result per request: read data, target code, serial transmit
// byte and the interrupt flag and enable registers after the access.
// Work ram, sprite ram and high ram share one synchronous store with a
// registered read; small i/o registers sit in flip-flops. Results are
// registered when the request executes. Throughput: one request per cycle
// while rsp_o is not held; the store is read at accept and written back
// at execute, with a same-slot bypass between the two.
// Stall: when rsp_o is held, the pending request stays in the execute
// stage and req_i drops ready until the response register frees up.
// Reset: a clearing pass writes zero to all 8576 store slots, one per
// cycle, and req_i is not ready during it; the apb port works throughout.
// The boot_rom_present register sits at byte address 0.
module handheld_memory_bus_decoder_core
  import hmbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  hmbd_req_if.sink          req_i,
  hmbd_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic boot_rom_present_q;
  logic cfg_hit;

  // execute stage request
  logic        busy_q;
  logic        op_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic        dma_q;
  logic [3:0]  act_q;
  logic [3:0]  dir_q;
  logic [4:0]  irq_set_q;

  // architectural registers
  logic [1:0] joy_sel_q, joy_sel_d;
  logic [7:0] ser_data_q, ser_data_d;
  logic [7:0] ser_ctrl_q, ser_ctrl_d;
  logic [4:0] irq_flags_q, irq_flags_d;
  logic [4:0] irq_mask_q, irq_mask_d;
  logic       boot_overlay_q, boot_overlay_d;

  // response register
  logic       rsp_valid_q;
  logic [7:0] rd_data_q, rd_data_d;
  target_e    tgt_q, tgt_d;
  logic       ser_valid_q, ser_valid_d;
  logic [7:0] ser_byte_q, ser_byte_d;
  logic [4:0] flags_out_q, mask_out_q;

  // handshake and store
  logic       store_ready;
  logic       exec_go;
  logic       req_fire;
  logic [7:0] mem_data;
  mem_rd_t    mem_rd;
  mem_wr_t    mem_wr;
  logic       mem_access;
  logic [4:0] flags_base;
  logic [3:0] joy_lines;

  // apb register
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PaddrW-1] == CfgIdxBootRom);
  assign prdata  = cfg_hit ? {31'b0, boot_rom_present_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_rom_present_q <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      boot_rom_present_q <= pwdata[0];
    end
  end

  // request flow
  assign exec_go     = busy_q && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = store_ready && (!busy_q || exec_go);

  // store read at accept
  assign mem_rd.en  = req_fire;
  assign mem_rd.idx = mem_index(req_i.address);

  hmbd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (mem_rd),
    .wr_i      (mem_wr),
    .rd_data_o (mem_data),
    .ready_o   (store_ready)
  );

  // joypad mux
  always_comb begin
    joy_lines = 4'hF;
    if (!joy_sel_q[1]) begin
      joy_lines = joy_lines & act_q;
    end
    if (!joy_sel_q[0]) begin
      joy_lines = joy_lines & dir_q;
    end
  end

  // decode and execute the pending access
  always_comb begin
    flags_base     = irq_flags_q | irq_set_q;
    rd_data_d      = 8'hFF;
    tgt_d          = TgtIgnored;
    ser_valid_d    = 1'b0;
    ser_byte_d     = 8'h00;
    mem_access     = 1'b0;
    joy_sel_d      = joy_sel_q;
    ser_data_d     = ser_data_q;
    ser_ctrl_d     = ser_ctrl_q;
    irq_flags_d    = flags_base;
    irq_mask_d     = irq_mask_q;
    boot_overlay_d = boot_overlay_q;

    if (addr_q >= AddrHramLo && addr_q != AddrIrqMask) begin
      tgt_d      = TgtInternal;
      mem_access = 1'b1;
    end else if (dma_q) begin
      tgt_d = TgtIgnored;
    end else if (addr_q < AddrBootEnd && !op_q && boot_overlay_q && boot_rom_present_q) begin
      tgt_d = TgtBoot;
    end else if (!addr_q[15]) begin
      tgt_d = TgtCart;
    end else if (addr_q <= AddrVramEnd) begin
      tgt_d = TgtVram;
    end else if (addr_q <= AddrXramEnd) begin
      tgt_d = TgtCart;
    end else if (addr_q <= AddrOamEnd) begin
      // work ram, echo and sprite ram
      tgt_d      = TgtInternal;
      mem_access = 1'b1;
    end else if (addr_q <= AddrHoleEnd) begin
      tgt_d = TgtIgnored;
    end else if (addr_q >= AddrTimerLo && addr_q <= AddrTimerHi) begin
      tgt_d = TgtTimer;
    end else if (addr_q >= AddrVideoLo && addr_q <= AddrVideoHi) begin
      tgt_d = TgtVideo;
    end else if (addr_q == AddrJoypad) begin
      tgt_d = TgtInternal;
      if (op_q) begin
        joy_sel_d = wdata_q[5:4];
      end else begin
        rd_data_d = {2'b11, joy_sel_q, joy_lines};
      end
    end else if (addr_q == AddrSerData) begin
      tgt_d = TgtInternal;
      if (op_q) begin
        ser_data_d = wdata_q;
      end else begin
        rd_data_d = ser_data_q;
      end
    end else if (addr_q == AddrSerCtrl) begin
      tgt_d = TgtInternal;
      if (op_q) begin
        ser_ctrl_d = wdata_q;
        // transfer start
        if (wdata_q[7]) begin
          ser_valid_d = 1'b1;
          ser_byte_d  = ser_data_q;
          ser_ctrl_d  = {1'b0, wdata_q[6:0]};
          irq_flags_d = flags_base | 5'b01000;
        end
      end else begin
        rd_data_d = ser_ctrl_q;
      end
    end else if (addr_q == AddrIrqFlags) begin
      tgt_d = TgtInternal;
      if (op_q) begin
        irq_flags_d = wdata_q[4:0];
      end else begin
        rd_data_d = {3'b111, flags_base};
      end
    end else if (addr_q == AddrBootOff) begin
      if (op_q) begin
        tgt_d          = TgtInternal;
        boot_overlay_d = 1'b0;
      end
    end else if (addr_q == AddrIrqMask) begin
      tgt_d = TgtInternal;
      if (op_q) begin
        irq_mask_d = wdata_q[4:0];
      end else begin
        rd_data_d = {3'b000, irq_mask_q};
      end
    end

    if (mem_access && !op_q) begin
      rd_data_d = mem_data;
    end
    if (op_q || tgt_d != TgtInternal) begin
      rd_data_d = 8'hFF;
    end
  end

  // store write back
  assign mem_wr.en   = exec_go && mem_access && op_q;
  assign mem_wr.idx  = mem_index(addr_q);
  assign mem_wr.data = wdata_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q      <= req_i.op;
      addr_q    <= req_i.address;
      wdata_q   <= req_i.write_data;
      dma_q     <= req_i.dma_busy;
      act_q     <= req_i.action_buttons;
      dir_q     <= req_i.direction_buttons;
      irq_set_q <= req_i.irq_set;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      rsp_valid_q    <= 1'b0;
      joy_sel_q      <= 2'b11;
      ser_data_q     <= 8'h00;
      ser_ctrl_q     <= 8'h00;
      irq_flags_q    <= 5'h00;
      irq_mask_q     <= 5'h00;
      boot_overlay_q <= 1'b1;
    end else begin
      if (req_fire) begin
        busy_q <= 1'b1;
      end else if (exec_go) begin
        busy_q <= 1'b0;
      end
      if (exec_go) begin
        rsp_valid_q    <= 1'b1;
        joy_sel_q      <= joy_sel_d;
        ser_data_q     <= ser_data_d;
        ser_ctrl_q     <= ser_ctrl_d;
        irq_flags_q    <= irq_flags_d;
        irq_mask_q     <= irq_mask_d;
        boot_overlay_q <= boot_overlay_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      rd_data_q   <= rd_data_d;
      tgt_q       <= tgt_d;
      ser_valid_q <= ser_valid_d;
      ser_byte_q  <= ser_byte_d;
      flags_out_q <= irq_flags_d;
      mask_out_q  <= irq_mask_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.read_data        = rd_data_q;
  assign rsp_o.target           = tgt_q;
  assign rsp_o.serial_valid     = ser_valid_q;
  assign rsp_o.serial_byte      = ser_byte_q;
  assign rsp_o.interrupt_flags  = flags_out_q;
  assign rsp_o.interrupt_enable = mask_out_q;

endmodule

@@ hw/rtl/hmbd_store.sv @@
module hmbd_store
  import hmbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_rd_t    rd_i,
  input  mem_wr_t    wr_i,
  output logic [7:0] rd_data_o,
  output logic       ready_o
);

  logic [7:0]       mem [MemDepth];
  logic [7:0]       rdata_q;
  logic             fwd_q;
  logic [7:0]       fwd_data_q;
  logic [MemAw-1:0] clr_idx_q;
  logic             clr_done_q;
  logic             we;
  logic [MemAw-1:0] widx;
  logic [7:0]       wdata;

  // clearing sweep owns the write port until done
  always_comb begin
    if (!clr_done_q) begin
      we    = 1'b1;
      widx  = clr_idx_q;
      wdata = 8'h00;
    end else begin
      we    = wr_i.en;
      widx  = wr_i.idx;
      wdata = wr_i.data;
    end
  end

  // array write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.idx];
    end
  end

  // bypass a write that lands on the slot being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      fwd_data_q <= 8'h00;
    end else if (rd_i.en) begin
      fwd_q      <= wr_i.en && (wr_i.idx == rd_i.idx);
      fwd_data_q <= wr_i.data;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_idx_q == MemAw'(MemDepth - 1)) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;
  assign ready_o   = clr_done_q;

endmodule

@@ hw/rtl/hmbd_checker.sv @@
`include "assert_macros.svh"

module hmbd_checker
  import hmbd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] read_data_i,
  input logic [2:0] target_i,
  input logic       serial_valid_i,
  input logic [7:0] serial_byte_i,
  input logic [4:0] interrupt_flags_i
);

  // no target code beyond the defined set
  `HMBD_NEVER(a_target_code, clk_i, rst_ni, rsp_valid_i && target_i == 3'd7, "bad target")

  // only internal reads return data other than all ones
  `HMBD_ASSERT(a_rdata_internal, clk_i, rst_ni, (rsp_valid_i && read_data_i != 8'hFF) |-> (target_i == TgtInternal), "read data from external target")

  // a serial start is internal and leaves the serial interrupt pending
  `HMBD_ASSERT(a_serial_irq, clk_i, rst_ni, (rsp_valid_i && serial_valid_i) |-> (interrupt_flags_i[3] && target_i == TgtInternal), "serial start without flag")

  // idle serial byte is zero
  `HMBD_ASSERT(a_serial_idle, clk_i, rst_ni, (rsp_valid_i && !serial_valid_i) |-> (serial_byte_i == 8'h00), "serial byte without start")

  // a stalled response holds
  `HMBD_ASSERT(a_rsp_hold, clk_i, rst_ni, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(read_data_i) && $stable(target_i) && $stable(interrupt_flags_i)), "response changed under stall")

endmodule

bind handheld_memory_bus_decoder_core hmbd_checker u_hmbd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .read_data_i       (rsp_o.read_data),
  .target_i          (rsp_o.target),
  .serial_valid_i    (rsp_o.serial_valid),
  .serial_byte_i     (rsp_o.serial_byte),
  .interrupt_flags_i (rsp_o.interrupt_flags)
);

@@ verif/tb_handheld_memory_bus_decoder_core.sv @@
`timescale 1ns / 1ps

module tb_handheld_memory_bus_decoder_core;
  import hmbd_pkg::*;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // region bounds that the package does not name
  localparam logic [15:0] VramLo = 16'h8000;
  localparam logic [15:0] WramLo = 16'hC000;
  localparam logic [15:0] EchoLo = 16'hE000;
  localparam logic [15:0] OamLo  = 16'hFE00;
  localparam logic [15:0] IoLo   = 16'hFF00;
  localparam logic [15:0] IoHi   = 16'hFF7F;

  localparam int HramBytes = 127;
  localparam int OamBytes  = 160;

  localparam logic [4:0] IrqSerial = 5'h08;
  localparam logic [PaddrW-1:0] BootRomCfgAddr = PaddrW'({CfgIdxBootRom, 2'b00});

  localparam int RandomPerPhase = 260;
  localparam int SettleCycles   = 8;
  localparam int CycleLimit     = 400000;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        dma;
    logic [3:0]  act_lines;
    logic [3:0]  dir_lines;
    logic [4:0]  irq_req;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    target_e    target;
    logic       serial_valid;
    logic [7:0] serial_byte;
    logic [4:0] irq_flags;
    logic [4:0] irq_enable;
  } bus_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  hmbd_req_if bus_req ();
  hmbd_rsp_if bus_rsp ();

  handheld_memory_bus_decoder_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bus_req),
    .rsp_o   (bus_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // decoder state as the bus sees it
  logic [7:0] wram_mem [0:WramDepth-1];
  logic [7:0] hram_mem [0:HramBytes-1];
  logic [7:0] oam_mem  [0:OamBytes-1];
  logic [1:0] pad_select;
  logic [7:0] ser_data;
  logic [7:0] ser_ctrl;
  logic [4:0] irq_pending;
  logic [4:0] irq_enable;
  logic       boot_mapped;
  logic       boot_rom_cfg;

  bus_result_t pending_decodes[$];
  logic [15:0] recent_writes[$];
  int unsigned cpu_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count;

  always #6 clk_i = ~clk_i;

  // decode one access through the memory map and update the state
  function automatic bus_result_t decode_access(input bus_access_t acc);
    bus_result_t res;
    logic        wr;
    logic [15:0] a;
    logic [15:0] slot;
    logic [3:0]  lines;
    a = acc.address;
    wr = (acc.op == OpWrite);
    res.read_data = 8'hFF;
    res.target = TgtIgnored;
    res.serial_valid = 1'b0;
    res.serial_byte = 8'h00;
    // outside requests land before the access is decoded
    irq_pending = irq_pending | acc.irq_req;
    if (a >= AddrHramLo && a != AddrIrqMask) begin
      slot = a - AddrHramLo;
      res.target = TgtInternal;
      if (wr) hram_mem[slot[6:0]] = acc.wdata;
      else res.read_data = hram_mem[slot[6:0]];
    end else if (acc.dma) begin
      res.target = TgtIgnored;
    end else if (a < AddrBootEnd && !wr && boot_mapped && boot_rom_cfg) begin
      res.target = TgtBoot;
    end else if (a < VramLo) begin
      res.target = TgtCart;
    end else if (a <= AddrVramEnd) begin
      res.target = TgtVram;
    end else if (a <= AddrXramEnd) begin
      res.target = TgtCart;
    end else if (a <= AddrEchoEnd) begin
      // echo mirrors the start of work ram
      slot = a - ((a >= EchoLo) ? EchoLo : WramLo);
      res.target = TgtInternal;
      if (wr) wram_mem[slot[12:0]] = acc.wdata;
      else res.read_data = wram_mem[slot[12:0]];
    end else if (a <= AddrOamEnd) begin
      slot = a - OamLo;
      res.target = TgtInternal;
      if (wr) oam_mem[slot[7:0]] = acc.wdata;
      else res.read_data = oam_mem[slot[7:0]];
    end else if (a <= AddrHoleEnd) begin
      res.target = TgtIgnored;
    end else if (a >= AddrTimerLo && a <= AddrTimerHi) begin
      res.target = TgtTimer;
    end else if (a >= AddrVideoLo && a <= AddrVideoHi) begin
      res.target = TgtVideo;
    end else if (a == AddrJoypad) begin
      res.target = TgtInternal;
      if (wr) begin
        pad_select = acc.wdata[5:4];
      end else begin
        lines = 4'hF;
        if (!pad_select[1]) lines = lines & acc.act_lines;
        if (!pad_select[0]) lines = lines & acc.dir_lines;
        res.read_data = {2'b11, pad_select, lines};
      end
    end else if (a == AddrSerData) begin
      res.target = TgtInternal;
      if (wr) ser_data = acc.wdata;
      else res.read_data = ser_data;
    end else if (a == AddrSerCtrl) begin
      res.target = TgtInternal;
      if (wr) begin
        ser_ctrl = acc.wdata;
        // start bit sends the data byte and raises the serial flag
        if (acc.wdata[7]) begin
          res.serial_valid = 1'b1;
          res.serial_byte = ser_data;
          ser_ctrl = {1'b0, acc.wdata[6:0]};
          irq_pending = irq_pending | IrqSerial;
        end
      end else begin
        res.read_data = ser_ctrl;
      end
    end else if (a == AddrIrqFlags) begin
      res.target = TgtInternal;
      if (wr) irq_pending = acc.wdata[4:0];
      else res.read_data = {3'b111, irq_pending};
    end else if (a == AddrBootOff) begin
      if (wr) begin
        res.target = TgtInternal;
        boot_mapped = 1'b0;
      end
    end else if (a == AddrIrqMask) begin
      res.target = TgtInternal;
      if (wr) irq_enable = acc.wdata[4:0];
      else res.read_data = {3'b000, irq_enable};
    end
    if (wr || res.target != TgtInternal) res.read_data = 8'hFF;
    res.irq_flags = irq_pending;
    res.irq_enable = irq_enable;
    return res;
  endfunction

  function automatic bus_access_t make_access(input logic op, input logic [15:0] addr,
                                              input logic [7:0] data, input logic dma);
    bus_access_t acc;
    acc.op = op;
    acc.address = addr;
    acc.wdata = data;
    acc.dma = dma;
    acc.act_lines = 4'($urandom_range(15));
    acc.dir_lines = 4'($urandom_range(15));
    acc.irq_req = 5'd0;
    return acc;
  endfunction

  // address mix weighted toward the internal regions
  function automatic logic [15:0] pick_address();
    logic [15:0] addr;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15 && recent_writes.size() > 0) begin
      addr = recent_writes[$urandom_range(recent_writes.size() - 1)];
    end else if (roll < 30) begin
      addr = 16'($urandom_range(AddrIrqMask - 1, AddrHramLo));
    end else if (roll < 45) begin
      addr = 16'($urandom_range(AddrEchoEnd, WramLo));
    end else if (roll < 55) begin
      addr = 16'($urandom_range(AddrHoleEnd, OamLo));
    end else if (roll < 75) begin
      case ($urandom_range(9))
        0: addr = AddrJoypad;
        1: addr = AddrSerData;
        2: addr = AddrSerCtrl;
        3: addr = AddrIrqFlags;
        4: addr = AddrIrqMask;
        5: addr = 16'($urandom_range(AddrTimerHi, AddrTimerLo));
        6: addr = 16'($urandom_range(AddrVideoHi, AddrVideoLo));
        7: addr = 16'($urandom_range(IoHi, IoLo));
        8: addr = AddrBootOff;
        default: addr = 16'($urandom_range(2 * AddrBootEnd - 1));
      endcase
    end else if (roll < 88) begin
      addr = 16'($urandom_range(AddrXramEnd));
    end else begin
      addr = 16'($urandom_range(16'hFFFF));
    end
    return addr;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("%0t: result %0d %s: got 'h%0h, expected 'h%0h",
             $time, result_count, what, got, want);
  endtask

  // drive one request and record its decode once accepted
  task automatic send_access(input bus_access_t acc);
    @(negedge clk_i);
    while ($urandom_range(99) < cpu_idle_pct) begin
      bus_req.valid <= 1'b0;
      @(negedge clk_i);
    end
    bus_req.valid             <= 1'b1;
    bus_req.op                <= acc.op;
    bus_req.address           <= acc.address;
    bus_req.write_data        <= acc.wdata;
    bus_req.dma_busy          <= acc.dma;
    bus_req.action_buttons    <= acc.act_lines;
    bus_req.direction_buttons <= acc.dir_lines;
    bus_req.irq_set           <= acc.irq_req;
    @(posedge clk_i);
    while (!bus_req.ready) @(posedge clk_i);
    pending_decodes.push_back(decode_access(acc));
  endtask

  // hold off requests until every outstanding result is back
  task automatic wait_for_results();
    @(negedge clk_i);
    bus_req.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  // apb write of the boot rom register, then read it back
  task automatic set_boot_rom_present(input logic value);
    wait_for_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BootRomCfgAddr;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    boot_rom_cfg = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value)) flag_mismatch("boot_rom_present readback", prdata, 32'(value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // boot overlay mapping with the boot rom attached and detached
  task automatic test_boot_rom_overlay();
    set_boot_rom_present(1'b1);
    send_access(make_access(OpRead, 16'h0000, 8'h00, 1'b0));
    send_access(make_access(OpRead, AddrBootEnd - 1, 8'h00, 1'b0));
    send_access(make_access(OpWrite, 16'h0000, 8'h5A, 1'b0));
    set_boot_rom_present(1'b0);
    send_access(make_access(OpRead, 16'h0000, 8'h00, 1'b0));
  endtask

  // region edges, echo aliasing, unusable space, high ram under dma
  task automatic test_memory_regions();
    send_access(make_access(OpRead, VramLo - 1, 8'h00, 1'b0));
    send_access(make_access(OpRead, VramLo, 8'h00, 1'b0));
    send_access(make_access(OpWrite, WramLo, 8'hA5, 1'b0));
    send_access(make_access(OpRead, EchoLo, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrEchoEnd, 8'h3C, 1'b0));
    send_access(make_access(OpRead, AddrEchoEnd - 16'h2000, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrOamEnd, 8'h81, 1'b0));
    send_access(make_access(OpRead, AddrOamEnd, 8'h00, 1'b0));
    send_access(make_access(OpRead, AddrOamEnd + 1, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrIrqMask - 1, 8'hFF, 1'b1));
    send_access(make_access(OpRead, AddrIrqMask - 1, 8'h00, 1'b1));
    send_access(make_access(OpRead, AddrHramLo, 8'h00, 1'b0));
  endtask

  // joypad mux, serial start, interrupt registers, routed and unmapped i/o
  task automatic test_io_registers();
    bus_access_t acc;
    send_access(make_access(OpWrite, AddrJoypad, 8'h00, 1'b0));
    send_access(make_access(OpRead, AddrJoypad, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrSerData, 8'h96, 1'b0));
    send_access(make_access(OpWrite, AddrSerCtrl, 8'h81, 1'b0));
    send_access(make_access(OpRead, AddrSerCtrl, 8'h00, 1'b0));
    acc = make_access(OpRead, AddrIrqFlags, 8'h00, 1'b0);
    acc.irq_req = 5'h1F;
    send_access(acc);
    send_access(make_access(OpWrite, AddrIrqFlags, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrIrqMask, 8'hFF, 1'b1));
    send_access(make_access(OpRead, AddrIrqMask, 8'h00, 1'b0));
    send_access(make_access(OpRead, AddrTimerHi, 8'h00, 1'b0));
    send_access(make_access(OpWrite, AddrVideoHi, 8'h77, 1'b0));
    send_access(make_access(OpRead, AddrBootOff, 8'h00, 1'b0));
  endtask

  // dropping the overlay unmaps the boot rom for good
  task automatic test_boot_rom_disable();
    set_boot_rom_present(1'b1);
    send_access(make_access(OpWrite, AddrBootOff, 8'h01, 1'b0));
    send_access(make_access(OpRead, 16'h0000, 8'h00, 1'b0));
  endtask

  // random accesses, many of them reading back recent writes
  task automatic test_random_traffic(input int count, input logic allow_boot_off);
    bus_access_t acc;
    for (int n = 0; n < count; n++) begin
      acc.op = $urandom_range(1) ? OpWrite : OpRead;
      acc.address = pick_address();
      if (acc.op == OpWrite && acc.address == AddrBootOff && !allow_boot_off) begin
        acc.op = OpRead;
      end
      acc.wdata = 8'($urandom_range(255));
      acc.dma = ($urandom_range(9) == 0);
      acc.act_lines = 4'($urandom_range(15));
      acc.dir_lines = 4'($urandom_range(15));
      acc.irq_req = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd0;
      if (acc.op == OpWrite) begin
        recent_writes.push_back(acc.address);
        if (recent_writes.size() > 16) void'(recent_writes.pop_front());
      end
      send_access(acc);
      if (n == count / 2 || $urandom_range(99) == 0) wait_for_results();
    end
  endtask

  // response ready with random stalls
  initial begin
    bus_rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      bus_rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // compare each returned result with the oldest outstanding decode
  always @(posedge clk_i) begin
    bus_result_t want;
    if (rst_ni === 1'b1 && bus_rsp.valid === 1'b1 && bus_rsp.ready === 1'b1) begin
      if (pending_decodes.size() == 0) begin
        flag_mismatch("unexpected result, target", 32'(bus_rsp.target), 32'd0);
      end else begin
        want = pending_decodes.pop_front();
        if (bus_rsp.read_data !== want.read_data)
          flag_mismatch("read_data", 32'(bus_rsp.read_data), 32'(want.read_data));
        if (bus_rsp.target !== want.target)
          flag_mismatch("target", 32'(bus_rsp.target), 32'(want.target));
        if (bus_rsp.serial_valid !== want.serial_valid)
          flag_mismatch("serial_valid", 32'(bus_rsp.serial_valid),
                        32'(want.serial_valid));
        if (bus_rsp.serial_byte !== want.serial_byte)
          flag_mismatch("serial_byte", 32'(bus_rsp.serial_byte), 32'(want.serial_byte));
        if (bus_rsp.interrupt_flags !== want.irq_flags)
          flag_mismatch("interrupt_flags", 32'(bus_rsp.interrupt_flags),
                        32'(want.irq_flags));
        if (bus_rsp.interrupt_enable !== want.irq_enable)
          flag_mismatch("interrupt_enable", 32'(bus_rsp.interrupt_enable),
                        32'(want.irq_enable));
      end
      result_count++;
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // reset, directed checks, then three random phases
  initial begin
    rst_ni = 1'b0;
    bus_req.valid = 1'b0;
    bus_req.op = OpRead;
    bus_req.address = '0;
    bus_req.write_data = '0;
    bus_req.dma_busy = 1'b0;
    bus_req.action_buttons = '0;
    bus_req.direction_buttons = '0;
    bus_req.irq_set = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < WramDepth; i++) wram_mem[i] = 8'h00;
    for (int i = 0; i < HramBytes; i++) hram_mem[i] = 8'h00;
    for (int i = 0; i < OamBytes; i++) oam_mem[i] = 8'h00;
    pad_select = 2'd3;
    ser_data = 8'h00;
    ser_ctrl = 8'h00;
    irq_pending = 5'd0;
    irq_enable = 5'd0;
    boot_mapped = 1'b1;
    boot_rom_cfg = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cpu_idle_pct = 38;
    rsp_stall_pct = 73;
    test_boot_rom_overlay();
    test_memory_regions();
    test_io_registers();
    set_boot_rom_present(1'b1);
    test_random_traffic(RandomPerPhase, 1'b0);

    cpu_idle_pct = 73;
    rsp_stall_pct = 38;
    set_boot_rom_present(1'b0);
    test_random_traffic(RandomPerPhase, 1'b0);
    test_boot_rom_disable();

    cpu_idle_pct = 0;
    rsp_stall_pct = 0;
    test_random_traffic(RandomPerPhase, 1'b1);

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hmbd_pkg.sv
hw/rtl/hmbd_if.sv
hw/rtl/hmbd_store.sv
hw/rtl/handheld_memory_bus_decoder_core.sv
hw/rtl/hmbd_checker.sv
verif/tb_handheld_memory_bus_decoder_core.sv
